>>> sv/pidq_pkg.sv
// ----------------------------------------------------------------------------
// pidq_pkg
// Shared sizes, codes and payload types of the positional insert dual queue.
// ----------------------------------------------------------------------------
package pidq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_QUEUES  = 2;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W       = (FILL_W > 8) ? FILL_W : 8;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_MOVE   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [31:0] name_tag;
      logic [15:0] category_tag;
      logic [7:0]  priority_tag;
   } entry_type;

   typedef enum logic [1:0] {
      ROW_HOLD   = 2'd0,
      ROW_INSERT = 2'd1,
      ROW_POP    = 2'd2
   } row_op_type;

   typedef struct packed {
      row_op_type       op;
      logic [IDX_W-1:0] pos;
      entry_type        entry;
   } row_cmd_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        queue_sel;
      logic [31:0] name_tag;
      logic [15:0] category_tag;
      logic [7:0]  priority_req;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        entry_valid;
      logic [31:0] out_name;
      logic [15:0] out_category;
      logic [7:0]  out_priority;
      logic [4:0]  fill_count;
      logic        is_empty;
   } rsp_payload_type;

endpackage

>>> sv/pidq_cell.sv
// ----------------------------------------------------------------------------
// pidq_cell
// One queue slot: holds an entry, loads a new one, or takes a neighbor's.
// ----------------------------------------------------------------------------
module pidq_cell (
   input  logic                      clock,
   input  logic [pidq_pkg::IDX_W-1:0] cell_index,
   input  pidq_pkg::row_cmd_type     cmd,
   input  pidq_pkg::entry_type       prev_entry,
   input  pidq_pkg::entry_type       next_entry,
   output pidq_pkg::entry_type       entry
);

   pidq_pkg::entry_type entry_ff;
   pidq_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         pidq_pkg::ROW_INSERT: begin
            // Slots behind the insert point move one place toward the tail.
            if (cell_index == cmd.pos) begin
               entry_in = cmd.entry;
            end else if (cell_index > cmd.pos) begin
               entry_in = prev_entry;
            end
         end
         pidq_pkg::ROW_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> sv/pidq_row.sv
// ----------------------------------------------------------------------------
// pidq_row
// One queue: a chain of cells with the head in cell zero, plus its fill count.
// ----------------------------------------------------------------------------
module pidq_row (
   input  logic                        clock,
   input  logic                        reset,
   input  pidq_pkg::row_cmd_type       cmd,
   output pidq_pkg::entry_type         head,
   output logic [pidq_pkg::FILL_W-1:0] fill
);

   pidq_pkg::entry_type cell_entry [pidq_pkg::QUEUE_DEPTH];

   logic [pidq_pkg::FILL_W-1:0] fill_ff;
   logic [pidq_pkg::FILL_W-1:0] fill_in;

   for (genvar i = 0; i < pidq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      pidq_pkg::entry_type prev_entry;
      pidq_pkg::entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = cmd.entry;
      end else begin : g_mid_prev
         assign prev_entry = cell_entry[i-1];
      end

      // The last cell has no neighbor behind it; on a pop it keeps its value.
      if (i == pidq_pkg::QUEUE_DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid_next
         assign next_entry = cell_entry[i+1];
      end

      pidq_cell u_cell (
         .clock      (clock),
         .cell_index (pidq_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i])
      );
   end

   always_comb begin
      case (cmd.op)
         pidq_pkg::ROW_INSERT: fill_in = fill_ff + pidq_pkg::FILL_W'(1);
         pidq_pkg::ROW_POP:    fill_in = fill_ff - pidq_pkg::FILL_W'(1);
         default:              fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head = cell_entry[0];
   assign fill = fill_ff;

endmodule

>>> sv/positional_insert_dual_queue_top.sv
// ----------------------------------------------------------------------------
// positional_insert_dual_queue_top
// Two bounded queues of tagged entries with append, positional insert,
// remove head and move head to the other queue.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high; busy never
// rises, so one transaction per cycle is sustained. Its result appears on
// rsp_data with rsp_strobe high for exactly one cycle, in the cycle after the
// transaction is taken, and the receiver cannot stall it. Each queue is a
// chain of cells in which every cell compares its slot index with the insert
// position and shifts in the same cycle.
// ----------------------------------------------------------------------------
module positional_insert_dual_queue_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  pidq_pkg::req_payload_type req_data,
   output logic                      rsp_strobe,
   output pidq_pkg::rsp_payload_type rsp_data
);

   pidq_pkg::row_cmd_type       row_cmd  [pidq_pkg::NUM_QUEUES];
   pidq_pkg::entry_type         row_head [pidq_pkg::NUM_QUEUES];
   logic [pidq_pkg::FILL_W-1:0] row_fill [pidq_pkg::NUM_QUEUES];

   for (genvar q = 0; q < pidq_pkg::NUM_QUEUES; q++) begin : g_row
      pidq_row u_row (
         .clock (clock),
         .reset (reset),
         .cmd   (row_cmd[q]),
         .head  (row_head[q]),
         .fill  (row_fill[q])
      );
   end

   logic                        sel;
   logic                        other;
   logic [pidq_pkg::FILL_W-1:0] fill_sel;
   logic [pidq_pkg::FILL_W-1:0] fill_other;
   logic                        full_sel;
   logic                        full_other;
   logic                        empty_sel;
   logic [pidq_pkg::IDX_W-1:0]  insert_pos;
   logic [pidq_pkg::FILL_W-1:0] fill_after;
   pidq_pkg::entry_type         new_entry;
   pidq_pkg::rsp_payload_type   rsp_in;
   pidq_pkg::rsp_payload_type   rsp_ff;
   logic                        strobe_ff;

   assign sel        = req_data.queue_sel;
   assign other      = ~req_data.queue_sel;
   assign fill_sel   = row_fill[sel];
   assign fill_other = row_fill[other];
   assign full_sel   = fill_sel >= pidq_pkg::FILL_W'(pidq_pkg::QUEUE_DEPTH);
   assign full_other = fill_other >= pidq_pkg::FILL_W'(pidq_pkg::QUEUE_DEPTH);
   assign empty_sel  = fill_sel == '0;

   assign new_entry.name_tag     = req_data.name_tag;
   assign new_entry.category_tag = req_data.category_tag;
   assign new_entry.priority_tag = req_data.priority_req;

   // Positions past the count go to the tail; one and below go to the front.
   always_comb begin
      if (req_data.req_type == pidq_pkg::REQ_APPEND ||
          pidq_pkg::CMP_W'(req_data.priority_req) > pidq_pkg::CMP_W'(fill_sel)) begin
         insert_pos = pidq_pkg::IDX_W'(fill_sel);
      end else if (req_data.priority_req <= 8'd1) begin
         insert_pos = '0;
      end else begin
         insert_pos = pidq_pkg::IDX_W'(req_data.priority_req - 8'd1);
      end
   end

   always_comb begin
      for (int q = 0; q < pidq_pkg::NUM_QUEUES; q++) begin
         row_cmd[q].op    = pidq_pkg::ROW_HOLD;
         row_cmd[q].pos   = insert_pos;
         row_cmd[q].entry = new_entry;
      end
      rsp_in              = '0;
      fill_after          = fill_sel;

      if (start) begin
         case (req_data.req_type)
            pidq_pkg::REQ_APPEND, pidq_pkg::REQ_INSERT: begin
               if (full_sel) begin
                  rsp_in.status = pidq_pkg::STATUS_FULL;
               end else begin
                  row_cmd[sel].op = pidq_pkg::ROW_INSERT;
                  fill_after      = fill_sel + pidq_pkg::FILL_W'(1);
               end
            end
            pidq_pkg::REQ_REMOVE: begin
               if (empty_sel) begin
                  rsp_in.status = pidq_pkg::STATUS_EMPTY;
               end else begin
                  row_cmd[sel].op    = pidq_pkg::ROW_POP;
                  rsp_in.entry_valid = 1'b1;
                  fill_after         = fill_sel - pidq_pkg::FILL_W'(1);
               end
            end
            pidq_pkg::REQ_MOVE: begin
               // An empty source is reported ahead of a full target.
               if (empty_sel) begin
                  rsp_in.status = pidq_pkg::STATUS_EMPTY;
               end else if (full_other) begin
                  rsp_in.status = pidq_pkg::STATUS_FULL;
               end else begin
                  row_cmd[sel].op      = pidq_pkg::ROW_POP;
                  row_cmd[other].op    = pidq_pkg::ROW_INSERT;
                  row_cmd[other].pos   = pidq_pkg::IDX_W'(fill_other);
                  row_cmd[other].entry = row_head[sel];
                  rsp_in.entry_valid   = 1'b1;
                  fill_after           = fill_sel - pidq_pkg::FILL_W'(1);
               end
            end
            default: begin
               rsp_in.status = pidq_pkg::STATUS_DONE;
            end
         endcase
      end

      if (rsp_in.entry_valid) begin
         rsp_in.out_name     = row_head[sel].name_tag;
         rsp_in.out_category = row_head[sel].category_tag;
         rsp_in.out_priority = row_head[sel].priority_tag;
      end
      rsp_in.fill_count = 5'(fill_after);
      rsp_in.is_empty   = fill_after == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
